>>> design/lcdmt_pkg.sv
// Shared types and constants of the LCD line and mode timing block.
package lcdmt_pkg;

	localparam int unsigned CountW = 10;
	localparam int unsigned LineW = 8;
	localparam int unsigned AddrW = 5;
	localparam int unsigned DataW = 32;

	localparam logic [CountW-1:0] LINE_CYCLES = 10'd456;
	localparam logic [CountW-1:0] HBLANK_AFTER = 10'd252;
	localparam logic [CountW-1:0] TRANSFER_AFTER = 10'd80;
	localparam logic [LineW-1:0] LAST_LINE = 8'd153;
	localparam logic [LineW-1:0] FIRST_VBLANK_LINE = 8'd144;

	// Register indexes on the configuration port.
	typedef enum logic [2:0] {
		REG_COMPARE_LINE = 3'd0,
		REG_HBLANK_IRQ_EN = 3'd1,
		REG_VBLANK_STAT_IRQ_EN = 3'd2,
		REG_OAM_IRQ_EN = 3'd3,
		REG_COINC_IRQ_EN = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM = 2'd2,
		MODE_TRANSFER = 2'd3
	} lcd_mode_t;

	typedef struct packed {
		logic [LineW-1:0] compare_line;
		logic hblank_irq_enable;
		logic vblank_stat_irq_enable;
		logic oam_irq_enable;
		logic coincidence_irq_enable;
	} cfg_t;

endpackage

>>> design/lcdmt_cfg.sv
// Configuration register file of the LCD timing block, written over an APB-style port.
module lcdmt_cfg import lcdmt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_sel;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_sel = paddr[AddrW-1:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_COMPARE_LINE: cfg_q.compare_line <= pwdata[LineW-1:0];
				REG_HBLANK_IRQ_EN: cfg_q.hblank_irq_enable <= pwdata[0];
				REG_VBLANK_STAT_IRQ_EN: cfg_q.vblank_stat_irq_enable <= pwdata[0];
				REG_OAM_IRQ_EN: cfg_q.oam_irq_enable <= pwdata[0];
				REG_COINC_IRQ_EN: cfg_q.coincidence_irq_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_COMPARE_LINE: prdata[LineW-1:0] = cfg_q.compare_line;
			REG_HBLANK_IRQ_EN: prdata[0] = cfg_q.hblank_irq_enable;
			REG_VBLANK_STAT_IRQ_EN: prdata[0] = cfg_q.vblank_stat_irq_enable;
			REG_OAM_IRQ_EN: prdata[0] = cfg_q.oam_irq_enable;
			REG_COINC_IRQ_EN: prdata[0] = cfg_q.coincidence_irq_enable;
			default: prdata = '0;
		endcase
	end

endmodule

>>> design/lcd_line_mode_timing_top.sv
// Top level of the LCD line and mode timing block: input register, step logic, result register.
// A word accepted into the input register passes the step logic into the result register,
// from which its result word is presented. Throughput: one word per cycle while the result
// channel is not stalled; the line counter and mode update is a single add, compare and
// decode between the input register and the result register.
// Reset (arst_n low, asynchronous) clears the counter, line, flags, configuration and valids.
module lcd_line_mode_timing_top import lcdmt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// Input channel.
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [7:0]       elapsed_cycles,
	// Result channel.
	output logic             result_valid,
	input  logic             result_stall,
	output logic [LineW-1:0] line,
	output logic [1:0]       mode,
	output logic             coincidence,
	output logic             vblank_irq,
	output logic             stat_irq,
	output logic             render_strobe,
	// Configuration port.
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	cfg_t cfg;

	lcdmt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] elapsed_s1;

	// Result register stage.
	logic             valid_s2;
	logic [LineW-1:0] line_s2;
	lcd_mode_t        mode_s2;
	logic             coinc_s2;
	logic             vblank_irq_s2;
	logic             stat_irq_s2;
	logic             render_s2;

	// Timing state, updated only when a word moves from stage 1 into the result register.
	logic [CountW-1:0] count_q;
	logic [LineW-1:0]  line_q;
	logic              vblank_seen_q;
	lcd_mode_t         last_mode_q;

	// The result register can take a new word when it is empty or its word leaves now.
	// Stage 1 moves on whenever the result register can take it, so the input side is
	// held off only when stage 1 is full and the output is blocked.
	logic advance;
	assign advance = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			elapsed_s1 <= elapsed_cycles;
		end
	end

	// Step logic. The sum fits in the counter width: the counter stays below 456 and
	// one word adds at most 255.
	logic [CountW-1:0] sum;
	logic [CountW-1:0] count_nxt;
	logic [LineW-1:0]  line_inc;
	logic [LineW-1:0]  line_nxt;
	logic              wrap;
	logic              render_nxt;
	logic              seen_base;
	logic              seen_nxt;
	logic              vblank_irq_nxt;
	lcd_mode_t         mode_nxt;
	logic              want_stat;
	logic              coinc_nxt;
	logic              stat_nxt;

	always_comb begin
		sum = count_q + {{(CountW-8){1'b0}}, elapsed_s1};
		wrap = (sum >= LINE_CYCLES);
		count_nxt = wrap ? '0 : sum;
		line_inc = wrap ? line_q + 8'd1 : line_q;
		render_nxt = wrap && (line_inc < FIRST_VBLANK_LINE);

		// Past the last line the frame starts over and the vblank flag is rearmed.
		if (line_inc > LAST_LINE) begin
			line_nxt = '0;
			seen_base = 1'b0;
		end else begin
			line_nxt = line_inc;
			seen_base = vblank_seen_q;
		end

		vblank_irq_nxt = 1'b0;
		seen_nxt = seen_base;
		want_stat = 1'b0;
		if (line_nxt >= FIRST_VBLANK_LINE) begin
			mode_nxt = MODE_VBLANK;
			vblank_irq_nxt = !seen_base;
			seen_nxt = 1'b1;
			want_stat = cfg.vblank_stat_irq_enable;
		end else if (count_nxt > HBLANK_AFTER) begin
			mode_nxt = MODE_HBLANK;
			want_stat = cfg.hblank_irq_enable;
		end else if (count_nxt > TRANSFER_AFTER) begin
			mode_nxt = MODE_TRANSFER;
		end else begin
			mode_nxt = MODE_OAM;
			want_stat = cfg.oam_irq_enable;
		end

		coinc_nxt = (line_nxt == cfg.compare_line);
		stat_nxt = (want_stat && (mode_nxt != last_mode_q))
			|| (coinc_nxt && cfg.coincidence_irq_enable);
	end

	logic step;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			line_q <= '0;
			vblank_seen_q <= 1'b0;
			last_mode_q <= MODE_HBLANK;
			valid_s2 <= 1'b0;
		end else begin
			if (step) begin
				count_q <= count_nxt;
				line_q <= line_nxt;
				vblank_seen_q <= seen_nxt;
				last_mode_q <= mode_nxt;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			line_s2 <= line_nxt;
			mode_s2 <= mode_nxt;
			coinc_s2 <= coinc_nxt;
			vblank_irq_s2 <= vblank_irq_nxt;
			stat_irq_s2 <= stat_nxt;
			render_s2 <= render_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign line = line_s2;
	assign mode = mode_s2;
	assign coincidence = coinc_s2;
	assign vblank_irq = vblank_irq_s2;
	assign stat_irq = stat_irq_s2;
	assign render_strobe = render_s2;

`ifndef SYNTHESIS
	// The stored timing state never leaves the range of one frame.
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < LINE_CYCLES) && (line_q <= LAST_LINE))
		else $error("line counter or line number out of range");

	// A new visible line always starts in OAM search.
	a_render_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && render_strobe) |-> (mode_s2 == MODE_OAM))
		else $error("render strobe outside OAM search");

	// The vblank interrupt is only raised in vblank mode and leaves the flag set.
	a_vblank_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && vblank_irq) |-> ((mode_s2 == MODE_VBLANK) && vblank_seen_q))
		else $error("vblank interrupt outside vblank");
`endif

endmodule

>>> bench/lcd_line_mode_timing_top_tb.sv
// Self-checking testbench for the LCD line and mode timing block.
`timescale 1ns / 100ps

module lcd_line_mode_timing_top_tb;
	import lcdmt_pkg::*;

	// The watchdog gives up after this many cycles in which no word moves on either channel.
	// The slowest legal stretch is a long sender gap or a long receiver stall plus a drain and
	// five register writes, so this leaves a wide margin.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned ITEMS_PER_PHASE = 235;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned MAX_REPORTS = 10;

	// One result word of the block, field by field.
	typedef struct packed {
		logic [LineW-1:0] line;
		lcd_mode_t mode;
		logic coincidence;
		logic vblank_irq;
		logic stat_irq;
		logic render_strobe;
	} lcd_status_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [7:0] elapsed_cycles;
	logic result_valid;
	logic result_stall;
	logic [LineW-1:0] line;
	logic [1:0] mode;
	logic coincidence;
	logic vblank_irq;
	logic stat_irq;
	logic render_strobe;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic pready;

	lcd_line_mode_timing_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.elapsed_cycles(elapsed_cycles),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.line(line),
		.mode(mode),
		.coincidence(coincidence),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq),
		.render_strobe(render_strobe),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Our own copy of the timing state and of the configuration registers.
	logic [CountW-1:0] line_cycles_seen = '0;
	logic [LineW-1:0] line_now = '0;
	logic vblank_flagged = 1'b0;
	lcd_mode_t mode_before = MODE_HBLANK;
	cfg_t timing_cfg = '0;

	// Expected status words, oldest first.
	lcd_status_t status_queue[$];

	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;

	// Phase-wide switches that turn off random idling, so some stretches run back to back.
	logic steady_sender = 1'b0;
	logic steady_receiver = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Advance the timing state by one word of elapsed cycles and return the status word it
	// should produce.
	function automatic lcd_status_t advance_line_timing(input logic [7:0] cycles);
		lcd_status_t s;
		logic [CountW-1:0] count;
		logic [LineW-1:0] ln;
		logic want_stat;
		s = '0;
		want_stat = 1'b0;
		count = line_cycles_seen + CountW'(cycles);
		ln = line_now;
		// A full line (the counter reaching LINE_CYCLES) moves to the next line; only visible lines get drawn.
		if (count >= LINE_CYCLES) begin
			count = '0;
			ln = ln + 8'd1;
			s.render_strobe = (ln < FIRST_VBLANK_LINE);
		end
		// Past the last vblank line the frame starts over and vblank may fire again.
		if (ln > LAST_LINE) begin
			ln = '0;
			vblank_flagged = 1'b0;
		end
		line_cycles_seen = count;
		line_now = ln;
		if (ln >= FIRST_VBLANK_LINE) begin
			s.mode = MODE_VBLANK;
			if (!vblank_flagged) begin
				s.vblank_irq = 1'b1;
				vblank_flagged = 1'b1;
			end
			want_stat = timing_cfg.vblank_stat_irq_enable;
		end else if (count > HBLANK_AFTER) begin
			s.mode = MODE_HBLANK;
			want_stat = timing_cfg.hblank_irq_enable;
		end else if (count > TRANSFER_AFTER) begin
			// Pixel transfer has no interrupt enable of its own.
			s.mode = MODE_TRANSFER;
		end else begin
			s.mode = MODE_OAM;
			want_stat = timing_cfg.oam_irq_enable;
		end
		// Mode interrupts fire on entry only, the coincidence one on every matching word.
		if (want_stat && s.mode != mode_before)
			s.stat_irq = 1'b1;
		mode_before = s.mode;
		s.coincidence = (ln == timing_cfg.compare_line);
		if (s.coincidence && timing_cfg.coincidence_irq_enable)
			s.stat_irq = 1'b1;
		s.line = ln;
		return s;
	endfunction

	function automatic string status_text(input lcd_status_t s);
		return $sformatf("line=%0d mode=%0d coincidence=%b vblank_irq=%b stat_irq=%b render=%b",
			s.line, s.mode, s.coincidence, s.vblank_irq, s.stat_irq, s.render_strobe);
	endfunction

	// Mostly back to back, sometimes a few idle cycles, rarely a long pause.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady_sender || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Elapsed-cycle counts lean large so that many frames pass, with enough small and zero
	// counts to sit on the mode boundaries.
	function automatic logic [7:0] pick_elapsed();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 8'($urandom_range(200, 255));
		if (roll < 85)
			return 8'($urandom_range(0, 255));
		if (roll < 97)
			return 8'($urandom_range(0, 8));
		return 8'd0;
	endfunction

	// Present one word, hold it until the block takes it, then record what it should produce.
	// Valid is lowered only ahead of a gap, so back-to-back words never see it drop.
	task automatic send_word(input logic [7:0] cycles);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		elapsed_cycles <= cycles;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		status_queue.push_back(advance_line_timing(cycles));
	endtask

	// Stop sending and wait until every expected word has come back, then let the pipeline
	// settle for a few more cycles.
	task automatic quiesce();
		item_valid <= 1'b0;
		while (status_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write: a setup phase, then an access phase that completes when pready is high,
	// then an idle phase with the bus released.
	// Upper data bits are random so that the block must keep only the register's own bits.
	task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
		logic [DataW-1:0] data;
		data = $urandom();
		if (idx == REG_COMPARE_LINE)
			data[7:0] = value;
		else
			data[0] = value[0];
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrW'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_COMPARE_LINE: timing_cfg.compare_line = data[7:0];
			REG_HBLANK_IRQ_EN: timing_cfg.hblank_irq_enable = data[0];
			REG_VBLANK_STAT_IRQ_EN: timing_cfg.vblank_stat_irq_enable = data[0];
			REG_OAM_IRQ_EN: timing_cfg.oam_irq_enable = data[0];
			REG_COINC_IRQ_EN: timing_cfg.coincidence_irq_enable = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] compare, input logic hblank_en,
			input logic vblank_en, input logic oam_en, input logic coinc_en);
		quiesce();
		write_reg(REG_COMPARE_LINE, compare);
		write_reg(REG_HBLANK_IRQ_EN, {7'd0, hblank_en});
		write_reg(REG_VBLANK_STAT_IRQ_EN, {7'd0, vblank_en});
		write_reg(REG_OAM_IRQ_EN, {7'd0, oam_en});
		write_reg(REG_COINC_IRQ_EN, {7'd0, coinc_en});
	endtask

	// With the reset configuration every enable is off and line 0 matches the compare line,
	// so coincidence shows without a status interrupt. Two full-size words wrap the first line.
	task automatic test_reset_defaults();
		send_word(8'd0);
		send_word(8'd255);
		send_word(8'd255);
		send_word(8'd80);
		send_word(8'd1);
	endtask

	// Walk the counter across each mode boundary with every enable set: 252 stays in transfer,
	// 253 enters hblank, 455 holds the line and 456 wraps it to a new line in OAM search.
	task automatic test_mode_boundaries();
		logic [7:0] steps[13];
		steps = '{8'd171, 8'd1, 8'd202, 8'd1, 8'd80, 8'd1, 8'd172, 8'd201, 8'd1, 8'd0,
			8'd255, 8'd200, 8'd128};
		apply_settings(8'd2, 1'b1, 1'b1, 1'b1, 1'b1);
		foreach (steps[i])
			send_word(steps[i]);
	endtask

	// Several frames of random words under a series of settings. The first phases pin the
	// extremes of the compare line (top, never matching, last line, first vblank line); later
	// ones are random. Draining before each change also makes the sender wait for every
	// outstanding word.
	task automatic test_random_frames();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_settings(8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
				1: apply_settings(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
				2: apply_settings(8'd153, 1'($urandom()), 1'b1, 1'($urandom()), 1'b1);
				3: apply_settings(8'd144, 1'b1, 1'($urandom()), 1'b1, 1'b1);
				default: apply_settings(8'($urandom_range(0, 153)), 1'($urandom()),
					1'($urandom()), 1'($urandom()), 1'($urandom()));
			endcase
			steady_sender = (p == 2);
			steady_receiver = (p == 2 || p == 5);
			repeat (ITEMS_PER_PHASE)
				send_word(pick_elapsed());
		end
		steady_sender = 1'b0;
		steady_receiver = 1'b0;
	endtask

	// Result side: compare each accepted word with the oldest expectation, then decide the
	// stall for the next cycle. Sampling right after the edge sees the pre-edge values.
	always @(posedge clk) begin
		lcd_status_t got;
		lcd_status_t want;
		int unsigned roll;
		if (arst_n && result_valid && !result_stall) begin
			got.line = line;
			got.mode = lcd_mode_t'(mode);
			got.coincidence = coincidence;
			got.vblank_irq = vblank_irq;
			got.stat_irq = stat_irq;
			got.render_strobe = render_strobe;
			if (status_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: unexpected word: %s", $realtime, status_text(got));
			end else begin
				want = status_queue.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected %s, got %s", $realtime, status_text(want),
							status_text(got));
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (steady_receiver || roll < 75) begin
				result_stall <= 1'b0;
			end else begin
				stall_left = (roll < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				result_stall <= 1'b1;
			end
		end
	end

	// Watchdog: a hang on either channel ends the run as a failure.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		elapsed_cycles = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		// Release reset away from the rising edge.
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_mode_boundaries();
		test_random_frames();
		quiesce();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && status_queue.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
